/* design/pst_pkg.sv */
// ----------------------------------------------------------------------------
// pst_pkg
// Types and codes shared by the pending session table and its scan engine.
// ----------------------------------------------------------------------------
package pst_pkg;

  // Request kinds; the two spare codes fall to a default arm
  typedef enum logic [2:0] {
    KIND_INSERT  = 3'd0,
    KIND_LOOKUP  = 3'd1,
    KIND_LOOKREM = 3'd2,
    KIND_TICK    = 3'd3,
    KIND_DELSLOT = 3'd4,
    KIND_DELKEY  = 3'd5
  } kind_e;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [7:0] TIMEOUT_RESET = 8'd30;

  // One accepted request
  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] key;
    logic [7:0]  msg_type;
    logic [1:0]  notify_kind;
    logic        sync_mode;
    logic [3:0]  slot;
  } req_t;

  // One result
  typedef struct packed {
    logic [1:0] status;
    logic [3:0] hit_slot;
    logic [7:0] found_msg_type;
    logic [1:0] found_notify_kind;
    logic       found_sync_mode;
    logic [4:0] expired_count;
  } res_t;

  // Stored table entry, excluding its valid bit
  typedef struct packed {
    logic [63:0] key;
    logic [7:0]  msg_type;
    logic [1:0]  notify_kind;
    logic        sync_mode;
    logic [7:0]  countdown;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

/* design/pending_session_table_with_aging.sv */
// Delete by slot and spare kinds are answered without a slot scan; insert,
//   lookup, remove and tick run the slot scan, which sets how long they take.
// Throughput: one request at a time; the next is taken in the cycle the previous
//   result is strobed, so delete by slot and spare kinds can run back to back.
// Results are strobed for one cycle on done_o; the receiver cannot stall.
// Reset clears all valid bits at once and loads timeout_q with 30.
// ----------------------------------------------------------------------------
// pending_session_table_with_aging
// Table of outstanding sessions keyed by a 64-bit id, with countdown aging.
// ----------------------------------------------------------------------------
module pending_session_table_with_aging #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [63:0] key_i,
  input  logic [7:0]  msg_type_i,
  input  logic [1:0]  notify_kind_i,
  input  logic        sync_mode_i,
  input  logic [3:0]  slot_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [3:0]  hit_slot_o,
  output logic [7:0]  found_msg_type_o,
  output logic [1:0]  found_notify_kind_o,
  output logic        found_sync_mode_o,
  output logic [4:0]  expired_count_o
);
  import pst_pkg::*;

  logic [7:0] timeout_q;
  logic       done_q;
  res_t       res_q;
  req_t       req;
  logic       scan_busy;
  logic       res_vld;
  res_t       res;

  assign req.kind        = kind_i;
  assign req.key         = key_i;
  assign req.msg_type    = msg_type_i;
  assign req.notify_kind = notify_kind_i;
  assign req.sync_mode   = sync_mode_i;
  assign req.slot        = slot_i;

  pst_scan #(
    .SLOTS (SLOTS)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .req_i     (req),
    .timeout_i (timeout_q),
    .busy_o    (scan_busy),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // Hold the timeout register and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      done_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      done_q <= res_vld;
    end
  end

  // Register the result fields
  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      res_q <= res;
    end
  end

  assign busy                = scan_busy;
  assign done_o              = done_q;
  assign status_o            = res_q.status;
  assign hit_slot_o          = res_q.hit_slot;
  assign found_msg_type_o    = res_q.found_msg_type;
  assign found_notify_kind_o = res_q.found_notify_kind;
  assign found_sync_mode_o   = res_q.found_sync_mode;
  assign expired_count_o     = res_q.expired_count;

endmodule

/* design/pst_ram.sv */
// ----------------------------------------------------------------------------
// pst_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module pst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write, and register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* design/pst_scan.sv */
// ----------------------------------------------------------------------------
// pst_scan
// Scan engine: valid bits in flops, entries in a RAM, one slot a cycle with
// the read of the next slot overlapping the update of the current one (insert checks only the valid bits).
// ----------------------------------------------------------------------------
module pst_scan #(
  parameter int unsigned SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  pst_pkg::req_t req_i,
  input  logic [7:0]    timeout_i,
  output logic          busy_o,
  output logic          res_vld_o,
  output pst_pkg::res_t res_o
);
  import pst_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  logic [SLOTS-1:0] valid_q, valid_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] ev_idx_q, ev_idx_d;
  logic             ev_vld_q, ev_vld_d;
  logic             rd_more_q, rd_more_d;
  logic [CNT_W-1:0] exp_q, exp_d;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [ENTRY_W-1:0] mem_rdata;
  entry_t           rd_entry;

  logic [8:0]       slot_w;
  logic [IDX_W-1:0] slot_idx;
  logic             slot_ok;
  logic             hit;

  assign rd_entry = entry_t'(mem_rdata);
  assign slot_w   = 9'(req_i.slot);
  assign slot_idx = slot_w[IDX_W-1:0];
  assign slot_ok  = 32'(req_i.slot) < 32'(SLOTS);
  assign hit      = valid_q[ev_idx_q] && (rd_entry.key == req_q.key);
  assign busy_o   = (state_q != ST_IDLE);

  pst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  // Sequence one request over the slots
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    valid_d   = valid_q;
    idx_d     = idx_q;
    ev_idx_d  = ev_idx_q;
    ev_vld_d  = 1'b0;
    rd_more_d = rd_more_q;
    exp_d     = exp_q;
    mem_we    = 1'b0;
    mem_waddr = ev_idx_q;
    mem_wdata = rd_entry;
    mem_re    = 1'b0;
    res_vld_o = 1'b0;
    res_o     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d     = req_i;
          idx_d     = '0;
          rd_more_d = 1'b1;
          exp_d     = '0;
          case (kind_e'(req_i.kind))
            KIND_DELSLOT: begin
              res_vld_o      = 1'b1;
              res_o.hit_slot = req_i.slot;
              if (slot_ok) begin
                valid_d[slot_idx] = 1'b0;
              end
            end
            KIND_INSERT, KIND_LOOKUP, KIND_LOOKREM, KIND_TICK, KIND_DELKEY: begin
              state_d = ST_SCAN;
            end
            default: begin
              res_vld_o = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (kind_e'(req_q.kind) == KIND_INSERT) begin
          // Take the lowest free slot
          if (!valid_q[idx_q]) begin
            mem_we                = 1'b1;
            mem_waddr             = idx_q;
            mem_wdata.key         = req_q.key;
            mem_wdata.msg_type    = req_q.msg_type;
            mem_wdata.notify_kind = req_q.notify_kind;
            mem_wdata.sync_mode   = req_q.sync_mode;
            mem_wdata.countdown   = timeout_i;
            valid_d[idx_q]        = 1'b1;
            res_vld_o             = 1'b1;
            res_o.hit_slot        = 4'(idx_q);
            state_d               = ST_IDLE;
          end else if (idx_q == LAST) begin
            res_vld_o    = 1'b1;
            res_o.status = STATUS_FULL;
            state_d      = ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          // Issue the read of the next slot
          if (rd_more_q) begin
            mem_re   = 1'b1;
            ev_vld_d = 1'b1;
            ev_idx_d = idx_q;
            if (idx_q == LAST) begin
              rd_more_d = 1'b0;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
          // Evaluate the slot read last cycle
          if (ev_vld_q) begin
            if (kind_e'(req_q.kind) == KIND_TICK) begin
              if (valid_q[ev_idx_q]) begin
                if (rd_entry.countdown == 8'd0) begin
                  valid_d[ev_idx_q] = 1'b0;
                  exp_d             = exp_q + 1'b1;
                end else begin
                  mem_we              = 1'b1;
                  mem_wdata.countdown = rd_entry.countdown - 8'd1;
                end
              end
              if (ev_idx_q == LAST) begin
                res_vld_o           = 1'b1;
                res_o.expired_count = 5'(exp_d);
                state_d             = ST_IDLE;
              end
            end else if (hit) begin
              res_vld_o      = 1'b1;
              res_o.hit_slot = 4'(ev_idx_q);
              if (kind_e'(req_q.kind) != KIND_DELKEY) begin
                res_o.found_msg_type    = rd_entry.msg_type;
                res_o.found_notify_kind = rd_entry.notify_kind;
                res_o.found_sync_mode   = rd_entry.sync_mode;
              end
              if (kind_e'(req_q.kind) != KIND_LOOKUP) begin
                valid_d[ev_idx_q] = 1'b0;
              end
              state_d = ST_IDLE;
            end else if (ev_idx_q == LAST) begin
              res_vld_o = 1'b1;
              if (kind_e'(req_q.kind) != KIND_DELKEY) begin
                res_o.status = STATUS_NOT_FOUND;
              end
              state_d = ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state, valid bits and scan pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      idx_q     <= '0;
      ev_idx_q  <= '0;
      ev_vld_q  <= 1'b0;
      rd_more_q <= 1'b0;
      exp_q     <= '0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      idx_q     <= idx_d;
      ev_idx_q  <= ev_idx_d;
      ev_vld_q  <= ev_vld_d;
      rd_more_q <= rd_more_d;
      exp_q     <= exp_d;
    end
  end

  // Request payload needs no reset
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

endmodule
